// ----- hw/rtl/small_set_table_unit_defines.svh -----
// ----------------------------------------------------------------------------
// small_set_table_unit_defines.svh
// Assertion macros for the small set table unit.
// ----------------------------------------------------------------------------
`ifndef SMALL_SET_TABLE_UNIT_DEFINES_SVH
`define SMALL_SET_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SST_ASSERT_NOW(lbl, ante, cons)
`define SST_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/sst_pkg.sv -----
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and request codes of the small set table unit.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int REQ_W = 2;
  localparam int VAL_W = 32;

  typedef logic [REQ_W-1:0] req_t;

  localparam req_t REQ_ADD    = 2'd0;
  localparam req_t REQ_REMOVE = 2'd1;
  localparam req_t REQ_SEARCH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic load;
    logic match;
    logic apply;
  } cmd_t;

endpackage

// ----- hw/rtl/sst_in_if.sv -----
// ----------------------------------------------------------------------------
// sst_in_if
// Request channel: operation code and value.
// ----------------------------------------------------------------------------
interface sst_in_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic signed [31:0]   item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

// ----- hw/rtl/sst_out_if.sv -----
// ----------------------------------------------------------------------------
// sst_out_if
// Result channel: success, full-reject flag, count and empty flag.
// ----------------------------------------------------------------------------
interface sst_out_if #(
  parameter int CntW = 5
);
  logic            valid;
  logic            ready;
  logic            success;
  logic            full_reject;
  logic [CntW-1:0] entry_count;
  logic            is_empty;

  modport source (output valid, output success, output full_reject, output entry_count,
                  output is_empty, input ready);
  modport sink   (input valid, input success, input full_reject, input entry_count,
                  input is_empty, output ready);
endinterface

// ----- hw/rtl/small_set_table_unit.sv -----
// ----------------------------------------------------------------------------
// small_set_table_unit
// Set of distinct 32-bit values packed at the front of a fixed table.
//
// Requests arrive on in_ch (req_type: add, remove or search; item_value).
// Each accepted request yields exactly one result on out_ch: success,
// full_reject, entry_count and is_empty, all taken after the request.
// A request runs through three steps: load, a parallel compare of every
// slot against the value, and the update of the entry row. The result is
// registered in the update step, which follows the compare step; no new
// request is accepted until that update is done, and the row update waits
// in its last step while the previous result is still held on out_ch.
// The receiver may stall for any time: the result register holds and the
// block takes one further request into its compare step meanwhile.
// Remove shifts every later slot down one place in the same update cycle.
// Reset (rst_n low, synchronous) empties the set and drops any pending
// result; slot contents are left as they are and never read until written.
// ----------------------------------------------------------------------------
module small_set_table_unit #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  sst_in_if.sink    in_ch,
  sst_out_if.source out_ch
);
  import sst_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  cmd_t cmd;

  sst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  sst_dpath #(
    .CAPACITY (CAPACITY),
    .CntW     (CNT_W)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_type     (in_ch.req_type),
    .in_item_value   (in_ch.item_value),
    .out_success     (out_ch.success),
    .out_full_reject (out_ch.full_reject),
    .out_entry_count (out_ch.entry_count),
    .out_is_empty    (out_ch.is_empty)
  );

endmodule

// ----- hw/rtl/sst_ctrl.sv -----
// ----------------------------------------------------------------------------
// sst_ctrl
// Request sequencer: load, match, apply; owns the result valid flag.
// ----------------------------------------------------------------------------
`include "small_set_table_unit_defines.svh"

module sst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output sst_pkg::cmd_t cmd
);
  import sst_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (!out_valid_r || out_ready) begin
          cmd.apply = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = out_valid_r;
    if (cmd.apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  `SST_ASSERT_NOW(a_apply_slot_free, cmd.apply, !out_valid_r || out_ready)
  `SST_ASSERT_NEXT(a_match_then_apply, state_r == ST_MATCH, state_r == ST_APPLY)
  `SST_ASSERT_NEXT(a_load_goes_match, in_valid && in_ready, state_r == ST_MATCH)

endmodule

// ----- hw/rtl/sst_dpath.sv -----
// ----------------------------------------------------------------------------
// sst_dpath
// Entry row with per-slot compare, shift-down on remove and result registers.
// ----------------------------------------------------------------------------
`include "small_set_table_unit_defines.svh"

module sst_dpath #(
  parameter int CAPACITY = 16,
  parameter int CntW     = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sst_pkg::cmd_t              cmd,
  input  logic [sst_pkg::REQ_W-1:0]  in_req_type,
  input  logic signed [sst_pkg::VAL_W-1:0] in_item_value,
  output logic                       out_success,
  output logic                       out_full_reject,
  output logic [CntW-1:0]            out_entry_count,
  output logic                       out_is_empty
);
  import sst_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);

  req_t              req_r;
  logic [VAL_W-1:0]  val_r;
  logic [VAL_W-1:0]  entries_r [CAPACITY];
  logic [VAL_W-1:0]  entries_nxt [CAPACITY];
  logic [CntW-1:0]   count_r, count_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [CAPACITY-1:0] match;
  logic              full, add_ok, rem_ok, ok, full_rej;
  logic              succ_r, full_rej_r, empty_r;
  logic [CntW-1:0]   cnt_out_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      val_r <= in_item_value;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cmp
    assign match[g] = (entries_r[g] == val_r) && (CntW'(g) < count_r);
  end

  always_comb begin
    pos_nxt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        pos_nxt = pos_nxt | IDX_W'(i);
      end
    end
    found_nxt = |match;
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      found_r <= found_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_comb begin
    full     = (count_r == CntW'(CAPACITY));
    add_ok   = 1'b0;
    rem_ok   = 1'b0;
    ok       = 1'b0;
    full_rej = 1'b0;
    unique case (req_r)
      REQ_ADD: begin
        add_ok   = !found_r && !full;
        full_rej = !found_r && full;
        ok       = add_ok;
      end
      REQ_REMOVE: begin
        rem_ok = found_r;
        ok     = found_r;
      end
      REQ_SEARCH: ok = found_r;
      default:    ok = 1'b0;
    endcase
    count_nxt = count_r;
    if (add_ok) begin
      count_nxt = count_r + CntW'(1);
    end else if (rem_ok) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_row
    if (g < CAPACITY - 1) begin : g_mid
      always_comb begin
        entries_nxt[g] = entries_r[g];
        if (add_ok && (CntW'(g) == count_r)) begin
          entries_nxt[g] = val_r;
        end else if (rem_ok && (IDX_W'(g) >= pos_r)) begin
          entries_nxt[g] = entries_r[g+1];
        end
      end
    end else begin : g_last
      always_comb begin
        entries_nxt[g] = entries_r[g];
        if (add_ok && (CntW'(g) == count_r)) begin
          entries_nxt[g] = val_r;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (cmd.apply) begin
        entries_r[g] <= entries_nxt[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.apply) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      succ_r     <= ok;
      full_rej_r <= full_rej;
      cnt_out_r  <= count_nxt;
      empty_r    <= (count_nxt == '0);
    end
  end

  assign out_success     = succ_r;
  assign out_full_reject = full_rej_r;
  assign out_entry_count = cnt_out_r;
  assign out_is_empty    = empty_r;

  `SST_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CntW'(CAPACITY))
  `SST_ASSERT_NEXT(a_remove_dec, cmd.apply && rem_ok, count_r == $past(count_r) - CntW'(1))
  `SST_ASSERT_NEXT(a_reject_no_success, cmd.apply && full_rej, !succ_r && count_r == $past(count_r))

endmodule
